// ===== sv/svhs_pkg.sv =====
package svhs_pkg;

	localparam int VERSION_BITS_DEF = 16;
	localparam int MAX_PROFILE_LEN  = 13;
	localparam int VERSION_W        = 16;
	localparam int OUT_TDATA_W      = 24;

	localparam logic [3:0] ES_LEN     = 4'd2;
	localparam logic [3:0] CORE_LEN   = 4'd4;
	localparam logic [3:0] COMPAT_LEN = 4'd13;

	localparam logic [1:0] PROF_NONE   = 2'd0;
	localparam logic [1:0] PROF_ES     = 2'd1;
	localparam logic [1:0] PROF_CORE   = 2'd2;
	localparam logic [1:0] PROF_COMPAT = 2'd3;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_V      = 8'h76;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       first_of_text;
		logic       last_of_text;
	} in_item_t;

	typedef struct packed {
		logic [VERSION_W-1:0] version_number;
		logic [1:0]           profile_kind;
		logic                 scan_flag;
	} res_t;

	typedef struct packed {
		logic res_valid;
		logic decided;
	} scan_stat_t;

	function automatic logic [7:0] kw_char(input logic [2:0] i);
		logic [7:0] r;
		case (i)
			3'd0: r = "v";
			3'd1: r = "e";
			3'd2: r = "r";
			3'd3: r = "s";
			3'd4: r = "i";
			3'd5: r = "o";
			3'd6: r = "n";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] es_char(input logic [3:0] i);
		logic [7:0] r;
		case (i)
			4'd0: r = "e";
			4'd1: r = "s";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] core_char(input logic [3:0] i);
		logic [7:0] r;
		case (i)
			4'd0: r = "c";
			4'd1: r = "o";
			4'd2: r = "r";
			4'd3: r = "e";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] compat_char(input logic [3:0] i);
		logic [7:0] r;
		case (i)
			4'd0:  r = "c";
			4'd1:  r = "o";
			4'd2:  r = "m";
			4'd3:  r = "p";
			4'd4:  r = "a";
			4'd5:  r = "t";
			4'd6:  r = "i";
			4'd7:  r = "b";
			4'd8:  r = "i";
			4'd9:  r = "l";
			4'd10: r = "i";
			4'd11: r = "t";
			4'd12: r = "y";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// Clear the candidate bits that the character at position n rules out.
	function automatic logic [2:0] prof_match(input logic [2:0] f, input logic [3:0] n,
		input logic [7:0] c);
		logic [2:0] r;
		r = f;
		if (n < ES_LEN && c != es_char(n)) r[0] = 1'b0;
		if (n < CORE_LEN && c != core_char(n)) r[1] = 1'b0;
		if (n < COMPAT_LEN && c != compat_char(n)) r[2] = 1'b0;
		return r;
	endfunction

	function automatic logic [1:0] prof_code(input logic [3:0] n, input logic [2:0] f);
		logic [1:0] r;
		r = PROF_NONE;
		if (n == ES_LEN && f[0]) r = PROF_ES;
		else if (n == CORE_LEN && f[1]) r = PROF_CORE;
		else if (n == COMPAT_LEN && f[2]) r = PROF_COMPAT;
		return r;
	endfunction

endpackage

// ===== sv/svhs_in_reg.sv =====
module svhs_in_reg
	import svhs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	input  logic     adv,
	output logic     valid_s1,
	output in_item_t item_s1
);

	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== sv/svhs_scan.sv =====
module svhs_scan
	import svhs_pkg::*;
#(
	parameter int VERSION_BITS = VERSION_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_s1,
	input  in_item_t   item_s1,
	input  logic       out_free,
	output logic       adv,
	output res_t       res,
	output scan_stat_t stat
);

	localparam logic [4:0] PH_WS        = 5'd0;
	localparam logic [4:0] PH_SLASH     = 5'd1;
	localparam logic [4:0] PH_LC_BODY   = 5'd2;
	localparam logic [4:0] PH_LC_EOL    = 5'd3;
	localparam logic [4:0] PH_LC_ESC    = 5'd4;
	localparam logic [4:0] PH_LC_ESC_CR = 5'd5;
	localparam logic [4:0] PH_BC_BODY   = 5'd6;
	localparam logic [4:0] PH_BC_STAR   = 5'd7;
	localparam logic [4:0] PH_HASH_WS   = 5'd8;
	localparam logic [4:0] PH_KEYWORD   = 5'd9;
	localparam logic [4:0] PH_VER_WS    = 5'd10;
	localparam logic [4:0] PH_DIGITS    = 5'd11;
	localparam logic [4:0] PH_PROF_WS   = 5'd12;
	localparam logic [4:0] PH_PROF      = 5'd13;

	localparam logic [2:0] KW_LEN   = 3'd7;
	localparam logic [3:0] PROF_MAX = 4'(MAX_PROFILE_LEN);

	logic [4:0]              phase_q, phase_n;
	logic [2:0]              kw_idx_q, kw_idx_n;
	logic [VERSION_BITS-1:0] acc_q, acc_n;
	logic                    ns_q, ns_n;
	logic [3:0]              plen_q, plen_n;
	logic [2:0]              pflags_q, pflags_n;
	logic                    decided_q, decided_n;

	logic [VERSION_BITS+3:0] mac;
	logic                    done, do_fail, do_fin, do_long, hit;

	logic [7:0] c;
	logic       c_blank, c_nl, c_space, c_neg, c_nonpos, c_pos, c_digit;

	assign c        = item_s1.text_byte;
	assign c_blank  = (c == CH_SP) || (c == CH_TAB);
	assign c_nl     = (c == CH_CR) || (c == CH_LF);
	assign c_space  = c_blank || c_nl;
	assign c_neg    = c[7];
	assign c_nonpos = c_neg || (c == 8'h00);
	assign c_pos    = !c_nonpos;
	assign c_digit  = (c >= CH_ZERO) && (c <= CH_NINE);

	always_comb begin
		phase_n  = phase_q;
		kw_idx_n = kw_idx_q;
		acc_n    = acc_q;
		ns_n     = ns_q;
		plen_n   = plen_q;
		pflags_n = pflags_q;
		decided_n = decided_q;
		do_fail  = 1'b0;
		do_fin   = 1'b0;
		do_long  = 1'b0;

		if (item_s1.first_of_text) begin
			phase_n   = PH_WS;
			kw_idx_n  = '0;
			acc_n     = '0;
			ns_n      = 1'b0;
			plen_n    = '0;
			pflags_n  = '1;
			decided_n = 1'b0;
		end

		mac = ({4'b0, acc_n} << 3) + ({4'b0, acc_n} << 1) + (VERSION_BITS+4)'(c[3:0]);

		done = decided_n;
		if (!done && phase_n > PH_PROF) phase_n = PH_WS;

		// Phases that hand the byte on come before their successors.
		if (!done && phase_n == PH_LC_EOL) begin
			if (c_nl) begin
				done = 1'b1;
			end else begin
				phase_n = PH_WS;
				if (c_nonpos) done = 1'b1;
			end
		end
		if (!done && phase_n == PH_WS) begin
			done = 1'b1;
			if (c_blank) begin
			end else if (c_nl) begin
				ns_n = 1'b1;
			end else if (c == CH_SLASH) begin
				ns_n    = 1'b1;
				phase_n = PH_SLASH;
			end else if (c == CH_HASH) begin
				phase_n = PH_HASH_WS;
			end else begin
				do_fail = 1'b1;
			end
		end
		if (!done && phase_n == PH_SLASH) begin
			done = 1'b1;
			if (c == CH_SLASH) phase_n = PH_LC_BODY;
			else if (c == CH_STAR) phase_n = PH_BC_BODY;
			else do_fail = 1'b1;
		end
		if (!done && phase_n == PH_LC_ESC_CR) begin
			phase_n = PH_LC_BODY;
			if (c == CH_LF) done = 1'b1;
		end
		if (!done && phase_n == PH_LC_BODY) begin
			done = 1'b1;
			if (c_nonpos) phase_n = PH_WS;
			else if (c_nl) phase_n = PH_LC_EOL;
			else if (c == CH_BSLASH) phase_n = PH_LC_ESC;
		end
		if (!done && phase_n == PH_LC_ESC) begin
			done    = 1'b1;
			phase_n = (c == CH_CR) ? PH_LC_ESC_CR : PH_LC_BODY;
		end
		if (!done && phase_n == PH_BC_STAR) begin
			if (c == CH_SLASH) begin
				phase_n = PH_WS;
				done    = 1'b1;
			end else begin
				phase_n = PH_BC_BODY;
			end
		end
		if (!done && phase_n == PH_BC_BODY) begin
			done = 1'b1;
			if (c_nonpos) phase_n = PH_WS;
			else if (c == CH_STAR) phase_n = PH_BC_STAR;
		end
		if (!done && phase_n == PH_HASH_WS) begin
			done = 1'b1;
			if (c_blank) begin
			end else if (c == CH_V) begin
				kw_idx_n = 3'd1;
				phase_n  = PH_KEYWORD;
			end else begin
				do_fail = 1'b1;
			end
		end
		if (!done && phase_n == PH_KEYWORD) begin
			done = 1'b1;
			if (kw_idx_n != KW_LEN && c == kw_char(kw_idx_n)) begin
				kw_idx_n = kw_idx_n + 3'd1;
				if (kw_idx_n == KW_LEN) phase_n = PH_VER_WS;
			end else begin
				do_fail = 1'b1;
			end
		end
		if (!done && phase_n == PH_VER_WS) begin
			if (c_blank) done = 1'b1;
			else phase_n = PH_DIGITS;
		end
		if (!done && phase_n == PH_DIGITS) begin
			if (c_digit) begin
				done  = 1'b1;
				acc_n = (mac[VERSION_BITS+3:VERSION_BITS] != 4'd0) ? '1 :
					mac[VERSION_BITS-1:0];
			end else if (acc_n == '0) begin
				done    = 1'b1;
				do_fail = 1'b1;
			end else begin
				phase_n = PH_PROF_WS;
			end
		end
		if (!done && phase_n == PH_PROF_WS) begin
			if (c_blank) done = 1'b1;
			else phase_n = PH_PROF;
		end
		if (!done && phase_n == PH_PROF) begin
			done = 1'b1;
			if (plen_n < PROF_MAX) begin
				if (c_neg || c_space) begin
					do_fin = 1'b1;
				end else begin
					pflags_n = prof_match(pflags_n, plen_n, c);
					plen_n   = plen_n + 4'd1;
				end
			end else if (c_pos && !c_space) begin
				do_long = 1'b1;
			end else begin
				do_fin = 1'b1;
			end
		end

		// End of text always settles the scan in the same step.
		if (!decided_n && !(do_fail || do_fin || do_long) && item_s1.last_of_text) begin
			case (phase_n)
				PH_VER_WS, PH_DIGITS: begin
					if (acc_n == '0) do_fail = 1'b1;
					else do_fin = 1'b1;
				end
				PH_PROF_WS, PH_PROF: do_fin = 1'b1;
				default: do_fail = 1'b1;
			endcase
		end

		hit = do_fail || do_fin || do_long;
		if (hit) decided_n = 1'b1;

		res.version_number = '0;
		res.profile_kind   = PROF_NONE;
		res.scan_flag      = 1'b1;
		if (do_long) begin
			res.version_number = VERSION_W'(acc_n);
		end else if (do_fin) begin
			res.version_number = VERSION_W'(acc_n);
			res.profile_kind   = prof_code(plen_n, pflags_n);
			res.scan_flag      = ns_n;
		end
	end

	assign adv            = valid_s1 && (!hit || out_free);
	assign stat.res_valid = valid_s1 && hit;
	assign stat.decided   = decided_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_WS;
			kw_idx_q  <= '0;
			acc_q     <= '0;
			ns_q      <= 1'b0;
			plen_q    <= '0;
			pflags_q  <= '1;
			decided_q <= 1'b0;
		end else if (adv) begin
			phase_q   <= phase_n;
			kw_idx_q  <= kw_idx_n;
			acc_q     <= acc_n;
			ns_q      <= ns_n;
			plen_q    <= plen_n;
			pflags_q  <= pflags_n;
			decided_q <= decided_n;
		end
	end

endmodule

// ===== sv/svhs_out_reg.sv =====
module svhs_out_reg
	import svhs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  res_t                   res,
	output logic                   out_free,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_TDATA_W-1:0] out_tdata,
	output logic                   out_tuser
);

	res_t res_q;

	assign out_free  = !out_valid || out_ready;
	assign out_tdata = OUT_TDATA_W'({res_q.profile_kind, res_q.version_number});
	assign out_tuser = res_q.scan_flag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && out_free) begin
			res_q <= res;
		end
	end

endmodule

// ===== sv/shader_version_header_scanner.sv =====
// Channel   Dir  Word contents (lowest bit first)
// s_axis    in   tdata[7:0] text_byte; tuser first_of_text; tlast last_of_text
// m_axis    out  tdata[15:0] version_number, [17:16] profile_kind, rest 0; tuser scan_flag
//
// One text byte per cycle, unless a byte with a result meets a stalled output.
// A byte is held in the input register; the scan state updates as it leaves,
// and its result lands in the output register at that same edge, raising tvalid.
// Reset (arst_n low) empties both registers and returns the scan to leading
// whitespace. A stalled output blocks only bytes that would produce a result;
// bytes that produce none keep flowing while a result waits.
module shader_version_header_scanner
	import svhs_pkg::*;
#(
	parameter int VERSION_BITS = VERSION_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,   // text_byte
	input  logic                   s_axis_tuser,   // first_of_text
	input  logic                   s_axis_tlast,   // last_of_text
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // version_number, profile_kind, pad
	output logic                   m_axis_tuser    // scan_flag
);

	in_item_t   in_item;
	in_item_t   item_s1;
	logic       valid_s1;
	logic       adv;
	logic       out_free;
	res_t       res;
	scan_stat_t stat;

	// Pack the incoming word into the item struct.
	assign in_item.text_byte     = s_axis_tdata;
	assign in_item.first_of_text = s_axis_tuser;
	assign in_item.last_of_text  = s_axis_tlast;

	// Input register: hold one byte until the scan can consume it.
	svhs_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// Scan state and the single-pass next-state logic; advance the byte when
	// it has no result or the output register can take one.
	svhs_scan #(
		.VERSION_BITS (VERSION_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.out_free (out_free),
		.adv      (adv),
		.res      (res),
		.stat     (stat)
	);

	// Output register: hold the result word until the sink takes it.
	svhs_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && stat.res_valid),
		.res       (res),
		.out_free  (out_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_tdata (m_axis_tdata),
		.out_tuser (m_axis_tuser)
	);

	// A byte that leaves with a result must show up at the output.
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv && stat.res_valid |=> m_axis_tvalid)
		else $error("result lost between scan and output register");

	// End of text on a live scan always settles it.
	a_eot_decides: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.last_of_text && !(stat.decided && !item_s1.first_of_text)
		|-> stat.res_valid)
		else $error("end of text left the scan undecided");

	// A byte stuck in the input register blocks the next one.
	a_s1_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |-> !s_axis_tready)
		else $error("input register overwritten while held");

endmodule
